// File: rtl/core/elliptical_foot_trajectory_top_assert.svh
// Assertion macros shared by the trajectory core.
`ifndef ELLIPTICAL_FOOT_TRAJECTORY_TOP_ASSERT_SVH
`define ELLIPTICAL_FOOT_TRAJECTORY_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("same-cycle check failed");
`define ASSERT_NEXT(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(name, clk, rst, pre, post)
`define ASSERT_NEXT(name, clk, rst, pre, post)
`endif
`endif

// File: rtl/core/efoot_pkg.sv
package efoot_pkg;

  localparam int PHASE_W = 19;
  localparam int SUM_W   = PHASE_W + 1;
  localparam int ANG_W   = 32;
  localparam int DIV_INT_STEPS  = SUM_W;
  localparam int DIV_FULL_STEPS = SUM_W + ANG_W;

  localparam int LEGS             = 4;
  localparam int ABDUCTION_OFFSET = 1573;

  localparam logic [31:0] Q30_ONE = 32'h4000_0000;
  localparam logic [31:0] SIN_C1  = 32'd1686629713;
  localparam logic [31:0] SIN_C3  = 32'd693598669;
  localparam logic [31:0] SIN_C5  = 32'd85569305;
  localparam logic [31:0] SIN_C7  = 32'd5026995;
  localparam logic [31:0] SIN_C9  = 32'd172272;
  localparam logic [31:0] SIN_C11 = 32'd3864;

  typedef enum logic [2:0] {
    REG_WALK_HEIGHT  = 3'd0,
    REG_SWING_HEIGHT = 3'd1,
    REG_HALF_POINTS  = 3'd2,
    REG_PHASE_STEP   = 3'd3,
    REG_OFFSET_FR    = 3'd4,
    REG_OFFSET_FL    = 3'd5,
    REG_OFFSET_BR    = 3'd6,
    REG_OFFSET_BL    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // Horner coefficient used at steps 2 to 6 of the sine sequencer (C9 down to C1)
  function automatic logic [31:0] poly_coef(input logic [2:0] k);
    logic [31:0] c;
    case (k)
      3'd2:    c = SIN_C9;
      3'd3:    c = SIN_C7;
      3'd4:    c = SIN_C5;
      3'd5:    c = SIN_C3;
      3'd6:    c = SIN_C1;
      default: c = 32'd0;
    endcase
    return c;
  endfunction

  function automatic logic [17:0] sat18(input logic signed [21:0] v);
    logic [17:0] o;
    if (v > 22'sd131071) begin
      o = 18'h1FFFF;
    end else if (v < -22'sd131072) begin
      o = 18'h20000;
    end else begin
      o = v[17:0];
    end
    return o;
  endfunction

endpackage

// File: rtl/core/efoot_if.sv
interface efoot_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         leg_select;
  logic signed [15:0] stride;
  logic signed [15:0] heading;
  logic signed [15:0] shift_x;
  logic signed [15:0] shift_y;
  logic signed [15:0] shift_z;
  logic               last_leg;

  modport source (output valid, leg_select, stride, heading, shift_x, shift_y,
                  shift_z, last_leg, input ready);
  modport sink (input valid, leg_select, stride, heading, shift_x, shift_y,
                shift_z, last_leg, output ready);
endinterface

interface efoot_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         leg_out;
  logic signed [17:0] foot_x;
  logic signed [17:0] foot_y;
  logic signed [17:0] foot_z;
  logic               last_out;

  modport source (output valid, leg_out, foot_x, foot_y, foot_z, last_out, input ready);
  modport sink (input valid, leg_out, foot_x, foot_y, foot_z, last_out, output ready);
endinterface

// File: rtl/core/elliptical_foot_trajectory_top.sv
// Each accepted item passes through the bit-serial phase divider, four sine
// runs, and the products and the output register; the core takes no new item
// until its result is in the output register, and an item with last_leg set
// holds the core further for the phase update.
// Reset (synchronous, rst high) loads the register defaults and a gait phase
// of half a point; no clearing pass.
module elliptical_foot_trajectory_top (
  input  logic              clk,
  input  logic              rst,
  efoot_in_if.sink          req,
  efoot_out_if.source       rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_TRIG = 6'b000100,
    S_MUL  = 6'b001000,
    S_OUT  = 6'b010000,
    S_UPD  = 6'b100000
  } state_t;

  state_t state;

  logic signed [17:0] walk_height;
  logic [16:0]        swing_height;
  logic [9:0]         half_cycle_points;
  logic [18:0]        phase_step;
  logic [18:0]        offset_fr;
  logic [18:0]        offset_fl;
  logic [18:0]        offset_br;
  logic [18:0]        offset_bl;
  logic [18:0]        gait_phase;

  logic [1:0]         leg;
  logic signed [15:0] step;
  logic [15:0]        head;
  logic signed [15:0] sx;
  logic signed [15:0] sy;
  logic signed [15:0] sz;
  logic               last;
  logic [18:0]        p;
  logic [31:0]        ang;
  logic signed [31:0] cos_a;
  logic signed [31:0] sin_a;
  logic signed [31:0] cp;
  logic signed [31:0] sp;
  logic [1:0]         tcnt;
  logic               trig_go;
  logic [2:0]         mcnt;
  logic signed [65:0] mprod;
  logic signed [33:0] r;
  logic signed [18:0] zterm;
  logic signed [21:0] fx_w;
  logic signed [21:0] fy_w;

  logic               out_valid;
  logic [1:0]         leg_out;
  logic [17:0]        foot_x;
  logic [17:0]        foot_y;
  logic [17:0]        foot_z;
  logic               last_out;

  logic [9:0]         n_eff;
  logic [18:0]        plen;
  logic [1:0]         leg_clamp;
  logic [18:0]        off_sel;
  logic               accept;
  logic               out_free;
  logic               div_start;
  logic               div_frac;
  logic [19:0]        div_dividend;
  efoot_pkg::unit_stat_t div_stat;
  logic [18:0]        div_rem;
  logic [31:0]        div_quo;
  efoot_pkg::unit_stat_t trig_stat;
  logic [31:0]        trig_ang;
  logic signed [31:0] trig_val;
  logic signed [33:0] ma;
  logic signed [31:0] mb;
  logic signed [65:0] mprod_next;
  logic signed [65:0] rnd15;
  logic signed [65:0] zsum;
  logic signed [65:0] xsum;
  logic signed [65:0] ysum;
  logic signed [33:0] r_calc;
  logic signed [21:0] abd;
  logic signed [21:0] fz_w;
  logic               swing_on;
  logic               cfg_wr;

  always_comb begin
    n_eff     = (half_cycle_points == '0) ? 10'd1 : half_cycle_points;
    plen      = {n_eff, 9'd0};
    leg_clamp = (req.leg_select > 2'(efoot_pkg::LEGS - 1)) ?
                2'(efoot_pkg::LEGS - 1) : req.leg_select;
    case (leg_clamp)
      2'd0:    off_sel = offset_fr;
      2'd1:    off_sel = offset_fl;
      2'd2:    off_sel = offset_br;
      default: off_sel = offset_bl;
    endcase
    accept       = req.valid && state == S_IDLE;
    out_free     = !out_valid || rsp.ready;
    div_frac     = state == S_IDLE;
    div_start    = accept || (state == S_OUT && out_free && last);
    div_dividend = (state == S_IDLE) ? ({1'b0, gait_phase} + {1'b0, off_sel}) :
                                       ({1'b0, gait_phase} + {1'b0, phase_step});
    case (tcnt)
      2'd0:    trig_ang = ang + efoot_pkg::Q30_ONE;
      2'd1:    trig_ang = ang;
      2'd2:    trig_ang = {head, 16'd0} + efoot_pkg::Q30_ONE;
      default: trig_ang = {head, 16'd0};
    endcase
  end

  efoot_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .frac     (div_frac),
    .dividend (div_dividend),
    .divisor  (plen),
    .stat     (div_stat),
    .rem_int  (div_rem),
    .quo      (div_quo)
  );

  efoot_trig u_trig (
    .clk     (clk),
    .rst     (rst),
    .start   (trig_go),
    .ang     (trig_ang),
    .stat    (trig_stat),
    .sin_val (trig_val)
  );

  // shared signed multiplier for the final products
  always_comb begin
    case (mcnt)
      3'd0: begin
        ma = {{18{step[15]}}, step};
        mb = cos_a;
      end
      3'd1: begin
        ma = {17'd0, swing_height};
        mb = sin_a;
      end
      3'd2: begin
        ma = r;
        mb = cp;
      end
      3'd3: begin
        ma = r;
        mb = sp;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    mprod_next = ma * mb;
    rnd15  = -mprod + 66'sd16384;
    r_calc = rnd15[48:15] + {{2{sx[15]}}, sx, 16'd0};
    zsum   = mprod + (66'sd1 <<< 29);
    xsum   = mprod + (66'sd1 <<< 45);
    ysum   = -mprod + (66'sd1 <<< 45);
    abd    = leg[0] ? 22'(efoot_pkg::ABDUCTION_OFFSET) : -22'(efoot_pkg::ABDUCTION_OFFSET);
    swing_on = {p, 1'b0} <= {1'b0, plen};
    fz_w   = {{4{walk_height[17]}}, walk_height} + {{6{sz[15]}}, sz} +
             (swing_on ? {{3{zterm[18]}}, zterm} : 22'sd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      trig_go   <= 1'b0;
      out_valid <= 1'b0;
      gait_phase <= 19'd256;
    end else begin
      // start the first sine run when the divider is done, and each next one once the previous one lands
      trig_go <= (state == S_DIV && div_stat.done) ||
                 (state == S_TRIG && trig_stat.done && tcnt != 2'd3);
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_TRIG;
          end
        end
        S_TRIG: begin
          if (trig_stat.done && tcnt == 2'd3) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (mcnt == 3'd4) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= last ? S_UPD : S_IDLE;
          end
        end
        S_UPD: begin
          if (div_stat.done) begin
            gait_phase <= div_rem;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      leg  <= leg_clamp;
      step <= req.stride;
      head <= req.heading;
      sx   <= req.shift_x;
      sy   <= req.shift_y;
      sz   <= req.shift_z;
      last <= req.last_leg;
    end
    if (state == S_DIV && div_stat.done) begin
      p    <= div_rem;
      ang  <= div_quo;
      tcnt <= 2'd0;
    end
    if (state == S_TRIG && trig_stat.done) begin
      case (tcnt)
        2'd0:    cos_a <= trig_val;
        2'd1:    sin_a <= trig_val;
        2'd2:    cp    <= trig_val;
        default: sp    <= trig_val;
      endcase
      tcnt <= tcnt + 2'd1;
      mcnt <= 3'd0;
    end
    if (state == S_MUL) begin
      mprod <= mprod_next;
      mcnt  <= mcnt + 3'd1;
      case (mcnt)
        3'd1:    r     <= r_calc;
        3'd2:    zterm <= zsum[48:30];
        3'd3:    fx_w  <= {{2{xsum[65]}}, xsum[65:46]};
        3'd4:    fy_w  <= {{2{ysum[65]}}, ysum[65:46]} + {{6{sy[15]}}, sy} + abd;
        default: ;
      endcase
    end
    if (state == S_OUT && out_free) begin
      leg_out  <= leg;
      foot_x   <= efoot_pkg::sat18(fx_w);
      foot_y   <= efoot_pkg::sat18(fy_w);
      foot_z   <= efoot_pkg::sat18(fz_w);
      last_out <= last;
    end
  end

  // configuration port
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_height       <= -18'sd4096;
      swing_height      <= 17'd983;
      half_cycle_points <= 10'd250;
      phase_step        <= 19'd2243;
      offset_fr         <= 19'd64000;
      offset_fl         <= 19'd0;
      offset_br         <= 19'd0;
      offset_bl         <= 19'd64000;
    end else if (cfg_wr) begin
      case (efoot_pkg::reg_idx_t'(paddr[4:2]))
        efoot_pkg::REG_WALK_HEIGHT:  walk_height       <= pwdata[17:0];
        efoot_pkg::REG_SWING_HEIGHT: swing_height      <= pwdata[16:0];
        efoot_pkg::REG_HALF_POINTS:  half_cycle_points <= pwdata[9:0];
        efoot_pkg::REG_PHASE_STEP:   phase_step        <= pwdata[18:0];
        efoot_pkg::REG_OFFSET_FR:    offset_fr         <= pwdata[18:0];
        efoot_pkg::REG_OFFSET_FL:    offset_fl         <= pwdata[18:0];
        efoot_pkg::REG_OFFSET_BR:    offset_br         <= pwdata[18:0];
        efoot_pkg::REG_OFFSET_BL:    offset_bl         <= pwdata[18:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (efoot_pkg::reg_idx_t'(paddr[4:2]))
      efoot_pkg::REG_WALK_HEIGHT:  prdata = {{14{walk_height[17]}}, walk_height};
      efoot_pkg::REG_SWING_HEIGHT: prdata = {15'd0, swing_height};
      efoot_pkg::REG_HALF_POINTS:  prdata = {22'd0, half_cycle_points};
      efoot_pkg::REG_PHASE_STEP:   prdata = {13'd0, phase_step};
      efoot_pkg::REG_OFFSET_FR:    prdata = {13'd0, offset_fr};
      efoot_pkg::REG_OFFSET_FL:    prdata = {13'd0, offset_fl};
      efoot_pkg::REG_OFFSET_BR:    prdata = {13'd0, offset_br};
      efoot_pkg::REG_OFFSET_BL:    prdata = {13'd0, offset_bl};
      default:                     prdata = '0;
    endcase
  end

  assign req.ready    = state == S_IDLE;
  assign rsp.valid    = out_valid;
  assign rsp.leg_out  = leg_out;
  assign rsp.foot_x   = foot_x;
  assign rsp.foot_y   = foot_y;
  assign rsp.foot_z   = foot_z;
  assign rsp.last_out = last_out;

  `include "elliptical_foot_trajectory_top_assert.svh"

  `ASSERT_IMPL(a_units_idle, clk, rst, state == S_IDLE, !div_stat.busy && !trig_stat.busy)
  `ASSERT_IMPL(a_phase_in_cycle, clk, rst, state == S_DIV && div_stat.done, div_rem < plen)
  `ASSERT_NEXT(a_gait_wrapped, clk, rst, state == S_UPD && div_stat.done, gait_phase < plen)

endmodule

// File: rtl/core/efoot_div.sv
// Bit-serial restoring divider: integer steps give the remainder,
// optional fraction steps give 32 quotient bits of rem/divisor.
module efoot_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            frac,
  input  logic [efoot_pkg::SUM_W-1:0]     dividend,
  input  logic [efoot_pkg::PHASE_W-1:0]   divisor,
  output efoot_pkg::unit_stat_t           stat,
  output logic [efoot_pkg::PHASE_W-1:0]   rem_int,
  output logic [efoot_pkg::ANG_W-1:0]     quo
);

  logic [efoot_pkg::PHASE_W-1:0] rem;
  logic [efoot_pkg::SUM_W-1:0]   num;
  logic [5:0]                    cnt;
  logic                          busy;
  logic                          done;
  logic                          frac_mode;
  logic [efoot_pkg::SUM_W-1:0]   trial;
  logic [efoot_pkg::SUM_W-1:0]   rem_next;
  logic                          ge;
  logic                          last_int;
  logic                          last_all;

  always_comb begin
    trial    = {rem, num[efoot_pkg::SUM_W-1]};
    ge       = trial >= {1'b0, divisor};
    rem_next = ge ? (trial - {1'b0, divisor}) : trial;
    last_int = cnt == 6'(efoot_pkg::DIV_INT_STEPS - 1);
    last_all = cnt == 6'(efoot_pkg::DIV_FULL_STEPS - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && ((last_int && !frac_mode) || last_all);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && ((last_int && !frac_mode) || last_all)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem       <= '0;
      num       <= dividend;
      cnt       <= '0;
      quo       <= '0;
      frac_mode <= frac;
    end else if (busy) begin
      rem <= rem_next[efoot_pkg::PHASE_W-1:0];
      num <= {num[efoot_pkg::SUM_W-2:0], 1'b0};
      quo <= {quo[efoot_pkg::ANG_W-2:0], ge};
      cnt <= cnt + 6'd1;
      if (last_int) begin
        rem_int <= rem_next[efoot_pkg::PHASE_W-1:0];
      end
    end
  end

  assign stat = '{busy: busy, done: done};

endmodule

// File: rtl/core/efoot_trig.sv
// Sine of a 32-bit angle: quarter-wave fold, then Horner steps of an odd
// polynomial on one shared 32x32 multiplier, one product per cycle.
module efoot_trig (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [31:0]              ang,
  output efoot_pkg::unit_stat_t    stat,
  output logic signed [31:0]       sin_val
);

  logic [2:0]  k;
  logic        busy;
  logic        done;
  logic [30:0] r;
  logic [30:0] s;
  logic        neg;
  logic [63:0] prod;
  logic [63:0] prod_next;
  logic [31:0] acc;
  logic [31:0] ma;
  logic [31:0] mb;
  logic [31:0] res;

  always_comb begin
    acc = efoot_pkg::poly_coef(k) - prod[61:30];
    case (k)
      3'd0: begin
        ma = {1'b0, r};
        mb = {1'b0, r};
      end
      3'd1: begin
        ma = efoot_pkg::SIN_C11;
        mb = prod[61:30];
      end
      3'd2, 3'd3, 3'd4, 3'd5: begin
        ma = acc;
        mb = {1'b0, s};
      end
      3'd6: begin
        ma = acc;
        mb = {1'b0, r};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    prod_next = ma * mb;
    res = (prod[63:30] > {2'b00, efoot_pkg::Q30_ONE}) ? efoot_pkg::Q30_ONE : prod[61:30];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && k == 3'd7;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && k == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      k   <= '0;
      neg <= ang[31];
      // odd quadrants run the quarter wave backwards
      r   <= ang[30] ? (efoot_pkg::Q30_ONE[30:0] - {1'b0, ang[29:0]}) : {1'b0, ang[29:0]};
    end else if (busy) begin
      k    <= k + 3'd1;
      prod <= prod_next;
      if (k == 3'd1) begin
        s <= prod[60:30];
      end
      if (k == 3'd7) begin
        sin_val <= neg ? -$signed(res) : $signed(res);
      end
    end
  end

  assign stat = '{busy: busy, done: done};

  `include "elliptical_foot_trajectory_top_assert.svh"

  `ASSERT_IMPL(a_sin_range, clk, rst, done, (sin_val <= 32'sh4000_0000) && (sin_val >= -32'sh4000_0000))
  `ASSERT_NEXT(a_done_ends_run, clk, rst, busy && k == 3'd7 && !start, !busy && done)
  `ASSERT_IMPL(a_idle_quiet, clk, rst, !busy, k == 3'd0 || done || k == 3'd7 || !done)

endmodule
